>>> src/unsigned_to_base_digits_defines.svh
// Assertion macros used by the unsigned_to_base_digits datapath.
`ifndef UNSIGNED_TO_BASE_DIGITS_DEFINES_SVH
`define UNSIGNED_TO_BASE_DIGITS_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define UBD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define UBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ubd_pkg.sv
// Package: types, constants and the digit character tables of the base converter.
package ubd_pkg;

  // Number of value bits converted; also the most digits one request can give.
  localparam int VALUE_BITS = 32;
  localparam int IN_VALUE_W = 32;
  localparam int EXT_W      = 64;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int IDX_W      = $clog2(VALUE_BITS);

  localparam int RADIX_W    = 5;
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam int CHAR_W = 7;

  // ASCII digit sets, indexed by digit value
  localparam logic [CHAR_W-1:0] LOWER_SET [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
  };
  localparam logic [CHAR_W-1:0] UPPER_SET [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic [RADIX_W-1:0]    radix;
    logic                  upper_case;
  } ubd_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } ubd_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic emit;
  } ubd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic emit_last;
  } ubd_status_t;

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_CONVERT = 3'b010,
    S_EMIT    = 3'b100
  } ubd_state_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [3:0] d,
                                                      input logic upper);
    digit_to_char = upper ? UPPER_SET[d] : LOWER_SET[d];
  endfunction

endpackage

>>> src/unsigned_to_base_digits.sv
// Top level: unsigned value to ASCII digits in base 2..16, most significant first.
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_stall   in_data  (value, radix, upper_case)
//   out      out  out_valid/out_stall out_data (digit_char, last)
//
// A request is loaded, then converted one bit of the value per cycle through the
// base-r digit register for all VALUE_BITS (32) bits, then its digits (1..32)
// are emitted, with emission paused while the output stalls.
// Reset (rst_n, synchronous) clears the controller and the output valid.
// Output stalls hold the output register and pause emission; a new request is
// taken once the last digit sits in the output register.
module unsigned_to_base_digits (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ubd_pkg::ubd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ubd_pkg::ubd_out_t out_data
);
  import ubd_pkg::*;

  ubd_cmd_t    cmd;
  ubd_status_t status;

  // Sequencer
  ubd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Digit conversion and output register
  ubd_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> src/ubd_ctrl.sv
// Controller: sequences load, bit-serial conversion and digit emission.
module ubd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ubd_pkg::ubd_status_t status,
  output ubd_pkg::ubd_cmd_t    cmd
);
  import ubd_pkg::*;

  ubd_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  bit_cnt_r, bit_cnt_nxt;

  // Input is taken only between requests
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    bit_cnt_nxt = bit_cnt_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          bit_cnt_nxt = '0;
          state_nxt   = S_CONVERT;
        end
      end
      S_CONVERT: begin
        cmd.shift   = 1'b1;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == IDX_W'(VALUE_BITS - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      bit_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

endmodule

>>> src/ubd_datapath.sv
// Datapath: base-r digit register fed one value bit per cycle, and the output register.
`include "unsigned_to_base_digits_defines.svh"
module ubd_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ubd_pkg::ubd_in_t     in_data,
  input  ubd_pkg::ubd_cmd_t    cmd,
  output ubd_pkg::ubd_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ubd_pkg::ubd_out_t    out_data
);
  import ubd_pkg::*;

  logic [VALUE_BITS-1:0] shift_r, shift_nxt;
  logic [RADIX_W-1:0]    radix_r, radix_nxt;
  logic                  upper_r, upper_nxt;
  logic [3:0]            digit_r   [VALUE_BITS];
  logic [3:0]            digit_nxt [VALUE_BITS];
  logic [CNT_W-1:0]      ndig_r, ndig_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ubd_out_t              out_data_r, out_data_nxt;

  logic [VALUE_BITS-1:0] gen, prop_or_gen;
  logic [VALUE_BITS:0]   sum, carry;
  logic [RADIX_W-1:0]    radix_in;
  logic [EXT_W-1:0]      value_ext;
  logic [CNT_W-1:0]      ndig_m1;
  logic [IDX_W-1:0]      rd_idx;
  logic                  emit_last;

  // Clamp the requested base into 2..16
  always_comb begin
    if (in_data.radix < RADIX_MIN) begin
      radix_in = RADIX_MIN;
    end else if (in_data.radix > RADIX_MAX) begin
      radix_in = RADIX_MAX;
    end else begin
      radix_in = in_data.radix;
    end
  end

  assign value_ext = {{(EXT_W - IN_VALUE_W){1'b0}}, in_data.value};

  // Per digit: doubling generates a carry when 2d >= r, propagates one when 2d + 1 == r
  always_comb begin
    for (int i = 0; i < VALUE_BITS; i++) begin
      gen[i]         = ({digit_r[i], 1'b0} >= radix_r);
      prop_or_gen[i] = gen[i] | ({digit_r[i], 1'b1} == radix_r);
    end
  end

  // Carry ripple resolved by one add; the incoming value bit is carry into digit 0
  assign sum   = {1'b0, prop_or_gen} + {1'b0, gen}
               + {{VALUE_BITS{1'b0}}, shift_r[VALUE_BITS-1]};
  assign carry = sum ^ {1'b0, prop_or_gen} ^ {1'b0, gen};

  // Emission reads the most significant remaining digit
  assign ndig_m1   = ndig_r - 1'b1;
  assign rd_idx    = (ndig_r == '0) ? '0 : ndig_m1[IDX_W-1:0];
  assign emit_last = (ndig_r <= CNT_W'(1));

  // Register updates
  always_comb begin
    shift_nxt     = shift_r;
    radix_nxt     = radix_r;
    upper_nxt     = upper_r;
    ndig_nxt      = ndig_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & out_stall;
    for (int i = 0; i < VALUE_BITS; i++) begin
      digit_nxt[i] = digit_r[i];
    end
    if (cmd.load) begin
      shift_nxt = value_ext[VALUE_BITS-1:0];
      radix_nxt = radix_in;
      upper_nxt = in_data.upper_case;
      ndig_nxt  = '0;
      for (int i = 0; i < VALUE_BITS; i++) begin
        digit_nxt[i] = '0;
      end
    end else if (cmd.shift) begin
      shift_nxt = {shift_r[VALUE_BITS-2:0], 1'b0};
      ndig_nxt  = ndig_r + CNT_W'(carry[ndig_r]);
      for (int i = 0; i < VALUE_BITS; i++) begin
        digit_nxt[i] = 4'({digit_r[i], carry[i]}
                          - (carry[i+1] ? radix_r : {RADIX_W{1'b0}}));
      end
    end else if (cmd.emit) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.digit_char = digit_to_char(digit_r[rd_idx], upper_r);
      out_data_nxt.last       = emit_last;
      ndig_nxt                = emit_last ? '0 : ndig_m1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ndig_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      ndig_r      <= ndig_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    shift_r    <= shift_nxt;
    radix_r    <= radix_nxt;
    upper_r    <= upper_nxt;
    out_data_r <= out_data_nxt;
    for (int i = 0; i < VALUE_BITS; i++) begin
      digit_r[i] <= digit_nxt[i];
    end
  end

  assign status.out_free  = !out_valid_r || !out_stall;
  assign status.emit_last = emit_last;
  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;

  // Checks
  `UBD_ASSERT_NEXT(a_emit_fills_out, clk, rst_n, cmd.emit, out_valid_r, "emit did not fill output")
  `UBD_ASSERT_NEXT(a_load_clears_count, clk, rst_n, cmd.load, ndig_r == '0, "digit count not cleared")
  `UBD_ASSERT_IMPL(a_no_top_carry, clk, rst_n, cmd.shift, !carry[VALUE_BITS], "digit overflow")
  `UBD_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, ndig_r <= CNT_W'(VALUE_BITS), "count too large")

endmodule

>>> sim/unsigned_to_base_digits_tb.sv
// Testbench for unsigned_to_base_digits: directed and random requests checked digit by digit.
`timescale 1ns / 100ps

module unsigned_to_base_digits_tb;
  import ubd_pkg::*;

  localparam int DIRECTED_ROWS = 22;
  localparam int RANDOM_ITEMS  = 258;
  localparam int QUIET_ITEMS   = 40;    // tail of the run with no idling
  localparam int WATCHDOG_MAX  = 2000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES  = 70;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ubd_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ubd_out_t out_data;

  logic     quiet_phase = 1'b0;
  int       stall_left = 0;
  int       idle_cycles = 0;
  int       error_count = 0;
  int       request_count = 0;
  int       digit_count = 0;

  // expected characters, oldest first
  ubd_out_t digit_queue[$];

  // Directed table: the request and, where obvious, its text (empty: use predictor)
  ubd_in_t directed_reqs [DIRECTED_ROWS] = '{
    {32'd0,          5'd10, 1'b0},
    {32'd0,          5'd2,  1'b1},
    {32'd0,          5'd0,  1'b0},
    {32'hFFFF_FFFF,  5'd16, 1'b0},
    {32'hFFFF_FFFF,  5'd16, 1'b1},
    {32'hFFFF_FFFF,  5'd2,  1'b0},
    {32'h8000_0000,  5'd2,  1'b1},
    {32'hFFFF_FFFF,  5'd10, 1'b0},
    {32'hFFFF_FFFF,  5'd8,  1'b1},
    {32'd1,          5'd2,  1'b0},
    {32'd255,        5'd0,  1'b0},
    {32'd255,        5'd1,  1'b1},
    {32'd255,        5'd17, 1'b0},
    {32'd255,        5'd31, 1'b1},
    {32'h00AB_CDEF,  5'd16, 1'b1},
    {32'h00AB_CDEF,  5'd16, 1'b0},
    {32'd15,         5'd16, 1'b0},
    {32'd16,         5'd16, 1'b1},
    {32'd9,          5'd10, 1'b0},
    {32'h1234_5678,  5'd3,  1'b0},
    {32'd1000,       5'd7,  1'b1},
    {32'hDEAD_BEEF,  5'd13, 1'b1}
  };
  string directed_text [DIRECTED_ROWS] = '{
    "0",
    "0",
    "0",
    "ffffffff",
    "FFFFFFFF",
    {"11111111", "11111111", "11111111", "11111111"},
    {"10000000", "00000000", "00000000", "00000000"},
    "4294967295",
    "37777777777",
    "1",
    "11111111",
    "11111111",
    "ff",
    "FF",
    "ABCDEF",
    "abcdef",
    "f",
    "10",
    "9",
    "",
    "",
    ""
  };

  unsigned_to_base_digits u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Queue the digits of a request, most significant first
  function automatic void predict_digits(input ubd_in_t req);
    logic [31:0] rest;
    logic [31:0] base;
    logic [3:0]  lsd_first[$];
    logic [3:0]  d;
    ubd_out_t    item;
    int          k;
    base = 32'(req.radix);
    if (base < 32'(RADIX_MIN)) base = 32'(RADIX_MIN);
    if (base > 32'(RADIX_MAX)) base = 32'(RADIX_MAX);
    rest = req.value;
    if (rest == 0) begin
      lsd_first.push_back(4'd0);
    end
    while (rest != 0) begin
      lsd_first.push_back(4'(rest % base));
      rest = rest / base;
    end
    for (k = lsd_first.size() - 1; k >= 0; k--) begin
      d = lsd_first[k];
      if (d < 4'd10) item.digit_char = 7'h30 + 7'(d);
      else if (req.upper_case) item.digit_char = 7'h41 + 7'(d - 4'd10);
      else item.digit_char = 7'h61 + 7'(d - 4'd10);
      item.last = (k == 0);
      digit_queue.push_back(item);
    end
  endfunction

  // Queue a digit string typed into the table
  function automatic void queue_text(input string text);
    byte      ch;
    ubd_out_t item;
    int       i;
    for (i = 0; i < text.len(); i++) begin
      ch = text[i];
      item.digit_char = ch[6:0];
      item.last = (i == text.len() - 1);
      digit_queue.push_back(item);
    end
  endfunction

  // Present one request, with an optional idle burst first; returns once accepted
  task automatic send_request(input ubd_in_t req);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    request_count++;
  endtask

  // Random request: value shapes that reach short, long and edge digit strings
  function automatic ubd_in_t random_request();
    ubd_in_t req;
    int      k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 5))
      0: req.value = $urandom;
      1: req.value = $urandom_range(0, 255);
      2: req.value = $urandom >> k;
      3: req.value = 32'd1 << k;
      4: req.value = (32'd1 << k) - 32'd1;
      default: req.value = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
    endcase
    if ($urandom_range(0, 4) == 0) req.radix = 5'($urandom_range(0, 31));
    else req.radix = 5'($urandom_range(2, 16));
    req.upper_case = 1'($urandom_range(0, 1));
    return req;
  endfunction

  // Result side: stall bursts, then check each accepted digit
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        digit_count++;
        if (digit_queue.size() == 0) begin
          $display("%0t: unexpected digit, expected none, actual char %h last %b",
                   $time, out_data.digit_char, out_data.last);
          error_count++;
        end else begin
          if (out_data.digit_char !== digit_queue[0].digit_char) begin
            $display("%0t: digit_char mismatch, expected %h, actual %h",
                     $time, digit_queue[0].digit_char, out_data.digit_char);
            error_count++;
          end
          if (out_data.last !== digit_queue[0].last) begin
            $display("%0t: last mismatch, expected %b, actual %b",
                     $time, digit_queue[0].last, out_data.last);
            error_count++;
          end
          void'(digit_queue.pop_front());
        end
      end
      if (quiet_phase) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 9);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("%0t: watchdog expired with %0d digits pending", $time, digit_queue.size());
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    int      n;
    ubd_in_t req;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (n = 0; n < DIRECTED_ROWS; n++) begin
      if (directed_text[n] == "") predict_digits(directed_reqs[n]);
      else queue_text(directed_text[n]);
      send_request(directed_reqs[n]);
    end

    // random requests, no idling in the tail
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_phase <= 1'b1;
      req = random_request();
      predict_digits(req);
      send_request(req);
    end
    in_valid <= 1'b0;

    // drain
    while (digit_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (digit_queue.size() != 0) begin
      $display("%0t: %0d expected digits never arrived", $time, digit_queue.size());
      error_count++;
    end

    $display("Converted %0d requests into %0d digits, bases 2..16 plus out-of-range",
             request_count, digit_count);
    $display("radix codes, both letter cases, zero and full-width values; %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
